// ===== src/avr_pkg.sv =====
// constants for the axis-angle vector rotate unit
// cordic step count, fixed-point formats and the arctangent table
package avr_pkg;

  localparam int N_STEPS = 24;
  localparam int FRAC = 16;

  localparam logic signed [32:0] ANG_PI = 33'sd843314857;
  localparam logic signed [32:0] ANG_TWO_PI = 33'sd1686629713;
  localparam logic signed [32:0] ANG_HALF_PI = 33'sd421657428;
  localparam logic signed [32:0] CORDIC_GAIN = 33'sd652032874;

  // arctangent of 2^-i in units of 2^-28 radian
  function automatic logic signed [31:0] atan_at(input int i);
    logic signed [31:0] r;
    case (i)
      0: r = 32'sd210828714;
      1: r = 32'sd124459457;
      2: r = 32'sd65760959;
      3: r = 32'sd33381290;
      4: r = 32'sd16755422;
      5: r = 32'sd8385879;
      6: r = 32'sd4193963;
      7: r = 32'sd2097109;
      8: r = 32'sd1048571;
      9: r = 32'sd524287;
      10: r = 32'sd262144;
      11: r = 32'sd131072;
      12: r = 32'sd65536;
      13: r = 32'sd32768;
      14: r = 32'sd16384;
      15: r = 32'sd8192;
      16: r = 32'sd4096;
      17: r = 32'sd2048;
      18: r = 32'sd1024;
      19: r = 32'sd512;
      20: r = 32'sd256;
      21: r = 32'sd128;
      22: r = 32'sd64;
      23: r = 32'sd32;
      24: r = 32'sd16;
      25: r = 32'sd8;
      26: r = 32'sd4;
      27: r = 32'sd2;
      28: r = 32'sd1;
      default: r = 32'sd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/axis_angle_vector_rotate_unit.sv =====
// rodrigues rotation of a vector about an axis, one transfer per cycle
// data passes the input regs, cordic chain, sine/cosine reg, e1 to e4 and output reg
// throughput one item per cycle; busy is always low and results are never held
// synchronous active-low reset clears the valid bits only
// depends on avr_pkg
module axis_angle_vector_rotate_unit
  import avr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [31:0] in_vec_x,
  input  logic [31:0] in_vec_y,
  input  logic [31:0] in_vec_z,
  input  logic [31:0] in_axis_x,
  input  logic [31:0] in_axis_y,
  input  logic [31:0] in_axis_z,
  input  logic [31:0] in_angle,
  output logic        out_valid,
  output logic [31:0] out_rot_x,
  output logic [31:0] out_rot_y,
  output logic [31:0] out_rot_z,
  output logic        out_overflow
);

  localparam int N = N_STEPS;
  localparam int LAT = N + 7;
  localparam int LO = 24;
  localparam int CS_W = 33;
  localparam int M_W = 34;
  localparam int CR_W = 64 - FRAC;
  localparam int DOT_W = 66 - FRAC;
  localparam int DQ_W = DOT_W + M_W;
  localparam int QW = DQ_W - 30;
  localparam int PDL_W = LO + 1 + M_W;
  localparam int PDH_W = DOT_W - LO + M_W;
  localparam int PCL_W = LO + 1 + CS_W;
  localparam int PCH_W = CR_W - LO + CS_W;
  localparam int PVC_W = 32 + CS_W;
  localparam int BASE_W = CR_W + CS_W + 1;
  localparam int PAL_W = 32 + LO + 1;
  localparam int PAH_W = 32 + QW - LO;
  localparam int PQ_W = 32 + QW;
  localparam int SUM_W = PQ_W + 30 - FRAC + 1;
  localparam int R_W = SUM_W - 30;

  logic accept;
  logic [LAT-1:0] vld_r;

  assign busy = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[LAT-2:0], accept};
    end
  end

  // angle wrap and quadrant fold
  logic signed [32:0] ang_w, ang_f;
  logic fold;

  always_comb begin
    ang_w = 33'($signed(in_angle));
    if (ang_w > ANG_PI) begin
      ang_w = ang_w - ANG_TWO_PI;
    end else if (ang_w < -ANG_PI) begin
      ang_w = ang_w + ANG_TWO_PI;
    end
    fold = 1'b0;
    ang_f = ang_w;
    if (ang_w > ANG_HALF_PI) begin
      ang_f = ang_w - ANG_PI;
      fold = 1'b1;
    end else if (ang_w < -ANG_HALF_PI) begin
      ang_f = ang_w + ANG_PI;
      fold = 1'b1;
    end
  end

  logic signed [CS_W-1:0] cx_r [0:N];
  logic signed [CS_W-1:0] cy_r [0:N];
  logic signed [31:0]     cz_r [0:N];
  logic                   flip_r [0:N];
  logic signed [31:0]     v0_r [0:2];
  logic signed [31:0]     a0_r [0:2];

  always_ff @(posedge clk) begin
    cx_r[0] <= CORDIC_GAIN;
    cy_r[0] <= '0;
    cz_r[0] <= ang_f[31:0];
    flip_r[0] <= fold;
    v0_r[0] <= $signed(in_vec_x);
    v0_r[1] <= $signed(in_vec_y);
    v0_r[2] <= $signed(in_vec_z);
    a0_r[0] <= $signed(in_axis_x);
    a0_r[1] <= $signed(in_axis_y);
    a0_r[2] <= $signed(in_axis_z);
  end

  // cordic chain, one step per stage
  for (genvar k = 0; k < N; k++) begin : g_step
    always_ff @(posedge clk) begin
      flip_r[k+1] <= flip_r[k];
      if (!cz_r[k][31]) begin
        cx_r[k+1] <= cx_r[k] - (cy_r[k] >>> k);
        cy_r[k+1] <= cy_r[k] + (cx_r[k] >>> k);
        cz_r[k+1] <= cz_r[k] - atan_at(k);
      end else begin
        cx_r[k+1] <= cx_r[k] + (cy_r[k] >>> k);
        cy_r[k+1] <= cy_r[k] - (cx_r[k] >>> k);
        cz_r[k+1] <= cz_r[k] + atan_at(k);
      end
    end
  end

  // side path: axis times vector products, then cross and dot
  logic signed [63:0] pav_r [0:2][0:2];
  logic signed [31:0] v1_r [0:2];
  logic signed [31:0] a1_r [0:2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      v1_r[i] <= v0_r[i];
      a1_r[i] <= a0_r[i];
      for (int j = 0; j < 3; j++) begin
        pav_r[i][j] <= 64'(a0_r[i]) * 64'(v0_r[j]);
      end
    end
  end

  logic signed [31:0]      sv_r  [2:N+1][0:2];
  logic signed [31:0]      sa_r  [2:N+1][0:2];
  logic signed [CR_W-1:0]  scr_r [2:N+1][0:2];
  logic signed [DOT_W-1:0] sdot_r [2:N+1];
  logic signed [63:0]      cr_full [0:2];
  logic signed [65:0]      dot_full;

  always_comb begin
    cr_full[0] = pav_r[1][2] - pav_r[2][1];
    cr_full[1] = pav_r[2][0] - pav_r[0][2];
    cr_full[2] = pav_r[0][1] - pav_r[1][0];
    dot_full = 66'(pav_r[0][0]) + 66'(pav_r[1][1]) + 66'(pav_r[2][2]);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      sv_r[2][i] <= v1_r[i];
      sa_r[2][i] <= a1_r[i];
      scr_r[2][i] <= cr_full[i][63:FRAC];
    end
    sdot_r[2] <= dot_full[65:FRAC];
    for (int k = 3; k <= N + 1; k++) begin
      sv_r[k] <= sv_r[k-1];
      sa_r[k] <= sa_r[k-1];
      scr_r[k] <= scr_r[k-1];
      sdot_r[k] <= sdot_r[k-1];
    end
  end

  // sine and cosine with the fold undone
  logic signed [CS_W-1:0] cs_r, sn_r;

  always_ff @(posedge clk) begin
    cs_r <= flip_r[N] ? -cx_r[N] : cx_r[N];
    sn_r <= flip_r[N] ? -cy_r[N] : cy_r[N];
  end

  // e1: partial products
  logic signed [M_W-1:0]   omc;
  logic signed [PDL_W-1:0] pdl_r;
  logic signed [PDH_W-1:0] pdh_r;
  logic signed [PVC_W-1:0] pvc_r [0:2];
  logic signed [PCL_W-1:0] pcl_r [0:2];
  logic signed [PCH_W-1:0] pch_r [0:2];
  logic signed [31:0]      a_e1_r [0:2];

  assign omc = (M_W'(1) <<< 30) - M_W'(cs_r);

  always_ff @(posedge clk) begin
    pdl_r <= PDL_W'($signed({1'b0, sdot_r[N+1][LO-1:0]})) * PDL_W'(omc);
    pdh_r <= PDH_W'($signed(sdot_r[N+1][DOT_W-1:LO])) * PDH_W'(omc);
    for (int i = 0; i < 3; i++) begin
      pvc_r[i] <= PVC_W'(sv_r[N+1][i]) * PVC_W'(cs_r);
      pcl_r[i] <= PCL_W'($signed({1'b0, scr_r[N+1][i][LO-1:0]})) * PCL_W'(sn_r);
      pch_r[i] <= PCH_W'($signed(scr_r[N+1][i][CR_W-1:LO])) * PCH_W'(sn_r);
      a_e1_r[i] <= sa_r[N+1][i];
    end
  end

  // e2: q and the cosine and sine terms
  logic signed [DQ_W-1:0]   dq_full;
  logic signed [QW-1:0]     q_r;
  logic signed [BASE_W-1:0] base_e2_r [0:2];
  logic signed [31:0]       a_e2_r [0:2];

  assign dq_full = (DQ_W'(pdh_r) <<< LO) + DQ_W'(pdl_r);

  always_ff @(posedge clk) begin
    q_r <= dq_full[DQ_W-1:30];
    for (int i = 0; i < 3; i++) begin
      base_e2_r[i] <= BASE_W'(pvc_r[i]) + (BASE_W'(pch_r[i]) <<< LO) + BASE_W'(pcl_r[i]);
      a_e2_r[i] <= a_e1_r[i];
    end
  end

  // e3: axis times q partial products
  logic signed [PAL_W-1:0]  pal_r [0:2];
  logic signed [PAH_W-1:0]  pah_r [0:2];
  logic signed [BASE_W-1:0] base_e3_r [0:2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pal_r[i] <= PAL_W'(a_e2_r[i]) * PAL_W'($signed({1'b0, q_r[LO-1:0]}));
      pah_r[i] <= PAH_W'(a_e2_r[i]) * PAH_W'($signed(q_r[QW-1:LO]));
      base_e3_r[i] <= base_e2_r[i];
    end
  end

  // e4: combine axis term
  logic signed [PQ_W-1:0]   pq_r [0:2];
  logic signed [BASE_W-1:0] base_e4_r [0:2];

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pq_r[i] <= (PQ_W'(pah_r[i]) <<< LO) + PQ_W'(pal_r[i]);
      base_e4_r[i] <= base_e3_r[i];
    end
  end

  // e5: final sum and saturation
  logic signed [SUM_W-1:0] sum [0:2];
  logic signed [R_W-1:0]   rsh [0:2];
  logic [31:0]             rot_nxt [0:2];
  logic [2:0]              sat;
  logic [31:0]             rot_r [0:2];
  logic                    ov_r;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sum[i] = SUM_W'(base_e4_r[i]) + (SUM_W'(pq_r[i]) <<< (30 - FRAC));
      rsh[i] = sum[i][SUM_W-1:30];
      sat[i] = !((&rsh[i][R_W-1:31]) || !(|rsh[i][R_W-1:31]));
      if (sat[i]) begin
        rot_nxt[i] = rsh[i][R_W-1] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        rot_nxt[i] = rsh[i][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      rot_r[i] <= rot_nxt[i];
    end
    ov_r <= |sat;
  end

  assign out_valid = vld_r[LAT-1];
  assign out_rot_x = rot_r[0];
  assign out_rot_y = rot_r[1];
  assign out_rot_z = rot_r[2];
  assign out_overflow = ov_r;

endmodule

// ===== tb/axis_angle_vector_rotate_unit_tb.sv =====
`timescale 1ns / 100ps
// testbench for axis_angle_vector_rotate_unit: directed table, then random transfers
// rotated vectors are predicted in-bench and checked in order; depends on avr_pkg
module axis_angle_vector_rotate_unit_tb;
  import avr_pkg::*;

  typedef struct {
    logic [31:0] vx, vy, vz, ax, ay, az, ang;
    bit          typed;
    logic [31:0] ex, ey, ez;
    logic        eov;
  } rot_item_t;

  typedef struct {
    logic [31:0] rx, ry, rz;
    logic        ov;
  } rot_res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [31:0] in_vec_x = '0, in_vec_y = '0, in_vec_z = '0;
  logic [31:0] in_axis_x = '0, in_axis_y = '0, in_axis_z = '0, in_angle = '0;
  logic        out_valid, out_overflow;
  logic [31:0] out_rot_x, out_rot_y, out_rot_z;

  rot_item_t   sent_q[$];
  rot_res_t    rot_exp_q[$];
  int          n_bad = 0;
  int          idle_pct = 0;

  axis_angle_vector_rotate_unit u_dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic signed [63:0] clamp_to(input logic signed [127:0] v, input int bits,
                                                  inout logic ov);
    logic signed [127:0] hi, lo;
    hi = (128'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      ov = 1'b1;
      return hi[63:0];
    end
    if (v < lo) begin
      ov = 1'b1;
      return lo[63:0];
    end
    return v[63:0];
  endfunction

  function automatic rot_res_t rotate_vec(input rot_item_t it);
    logic signed [63:0]  v[3], a[3], x, y, z, dx, dy, cs, sn, dot, q, cr;
    logic signed [127:0] acc, sum;
    logic                flip, ov, dummy;
    rot_res_t            r;
    int                  j, k;
    v[0] = 64'(signed'(it.vx)); v[1] = 64'(signed'(it.vy)); v[2] = 64'(signed'(it.vz));
    a[0] = 64'(signed'(it.ax)); a[1] = 64'(signed'(it.ay)); a[2] = 64'(signed'(it.az));
    z = 64'(signed'(it.ang));
    flip = 1'b0;
    if (z > ANG_PI) z = z - ANG_TWO_PI;
    else if (z < -ANG_PI) z = z + ANG_TWO_PI;
    if (z > ANG_HALF_PI) begin
      z = z - ANG_PI;
      flip = 1'b1;
    end else if (z < -ANG_HALF_PI) begin
      z = z + ANG_PI;
      flip = 1'b1;
    end
    x = CORDIC_GAIN;
    y = 0;
    for (int i = 0; i < N_STEPS; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x = x - dx; y = y + dy; z = z - atan_at(i);
      end else begin
        x = x + dx; y = y - dy; z = z + atan_at(i);
      end
    end
    cs = flip ? -x : x;
    sn = flip ? -y : y;
    dummy = 1'b0;
    ov = 1'b0;
    acc = 128'(a[0]) * 128'(v[0]) + 128'(a[1]) * 128'(v[1]) + 128'(a[2]) * 128'(v[2]);
    dot = clamp_to(acc >>> FRAC, 63, dummy);
    acc = 128'(dot) * (128'sd1073741824 - 128'(cs));
    q = clamp_to(acc >>> 30, 63, dummy);
    for (int i = 0; i < 3; i++) begin
      j = (i + 1) % 3;
      k = (i + 2) % 3;
      cr = (a[j] * v[k] - a[k] * v[j]) >>> FRAC;
      sum = 128'(v[i]) * 128'(cs) + 128'(cr) * 128'(sn)
          + ((128'(a[i]) * 128'(q)) <<< (30 - FRAC));
      if (i == 0) r.rx = 32'(clamp_to(sum >>> 30, 32, ov));
      else if (i == 1) r.ry = 32'(clamp_to(sum >>> 30, 32, ov));
      else r.rz = 32'(clamp_to(sum >>> 30, 32, ov));
    end
    r.ov = ov;
    return r;
  endfunction

  always @(posedge clk) begin
    rot_item_t it;
    rot_res_t  e;
    if (rst_n && start && !busy) begin
      it = sent_q.pop_front();
      if (it.typed) begin
        e.rx = it.ex; e.ry = it.ey; e.rz = it.ez; e.ov = it.eov;
      end else begin
        e = rotate_vec(it);
      end
      rot_exp_q.push_back(e);
    end
    if (rst_n && out_valid) begin
      if (rot_exp_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h %h %h %b",
                                  out_rot_x, out_rot_y, out_rot_z, out_overflow);
      end else begin
        e = rot_exp_q.pop_front();
        if (out_rot_x !== e.rx || out_rot_y !== e.ry || out_rot_z !== e.rz ||
            out_overflow !== e.ov) begin
          n_bad++;
          if (n_bad <= 10)
            $display("mismatch exp %h %h %h %b got %h %h %h %b", e.rx, e.ry, e.rz, e.ov,
                     out_rot_x, out_rot_y, out_rot_z, out_overflow);
        end
      end
    end
  end

  task automatic send_item(input rot_item_t it);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    sent_q.push_back(it);
    start <= 1'b1;
    in_vec_x <= it.vx; in_vec_y <= it.vy; in_vec_z <= it.vz;
    in_axis_x <= it.ax; in_axis_y <= it.ay; in_axis_z <= it.az;
    in_angle <= it.ang;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_comp();
    case ($urandom_range(3))
      0: return $urandom();
      1: return 32'(int'($urandom_range(524288)) - 262144);
      2: return 32'(int'($urandom_range(131072)) - 65536);
      default: return ($urandom_range(1)) ? 32'h7fffffff : 32'h80000000;
    endcase
  endfunction

  function automatic rot_item_t rand_item();
    rot_item_t it;
    it.vx = rand_comp(); it.vy = rand_comp(); it.vz = rand_comp();
    it.ax = rand_comp(); it.ay = rand_comp(); it.az = rand_comp();
    it.ang = 32'(int'($urandom_range(32'd3373259426)) - 1686629713);
    it.typed = 1'b0;
    return it;
  endfunction

  function automatic rot_item_t row(input logic [31:0] vx, vy, vz, ax, ay, az, ang,
                                    input bit typed = 0, input logic [31:0] ex = 0,
                                    ey = 0, ez = 0, input logic eov = 0);
    rot_item_t it;
    it = '{vx, vy, vz, ax, ay, az, ang, typed, ex, ey, ez, eov};
    return it;
  endfunction

  rot_item_t dir_tab[$];

  initial begin
    dir_tab.push_back(row(0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    dir_tab.push_back(row(0, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'd1686629713,
                          1, 0, 0, 0, 0));
    dir_tab.push_back(row(0, 0, 0, 32'h00010000, 0, 0, 32'(-1686629713), 1, 0, 0, 0, 0));
    dir_tab.push_back(row(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'd421657428));
    dir_tab.push_back(row(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'd843314857));
    dir_tab.push_back(row(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'(-843314857)));
    dir_tab.push_back(row(32'h00010000, 32'h00020000, 0, 0, 0, 0, 32'd210828714));
    dir_tab.push_back(row(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'd843314858));
    dir_tab.push_back(row(32'h00010000, 0, 0, 0, 0, 32'h00010000, 32'(-843314858)));
    dir_tab.push_back(row(32'h00010000, 32'h00010000, 0, 0, 0, 32'h00010000, 32'd421657429));
    dir_tab.push_back(row(32'h00010000, 32'h00010000, 0, 0, 0, 32'h00010000, 32'(-421657429)));
    dir_tab.push_back(row(32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                          32'h7fffffff, 32'h7fffffff, 32'd1686629713));
    dir_tab.push_back(row(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                          32'h80000000, 32'h80000000, 32'(-1686629713)));
    dir_tab.push_back(row(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                          32'h80000000, 32'h7fffffff, 32'd100000000));
    dir_tab.push_back(row(32'h7fffffff, 0, 0, 32'h00030000, 32'h00020000, 0, 32'd600000000));
    dir_tab.push_back(row(32'h12345678, 32'hfedcba98, 32'h0f0f0f0f, 32'h0000b505,
                          32'h0000b505, 0, 32'd300000000));
    dir_tab.push_back(row(32'hffffffff, 32'h00000001, 32'hffff0000, 32'h00008000,
                          32'hffff8000, 32'h00008000, 32'(-1000000000)));
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) send_item(dir_tab[i]);
    for (int n = 0; n < 500; n++) begin
      if (n % 125 == 0) idle_pct = (n / 125 == 1) ? 58 : (n / 125 == 3) ? 25 : 0;
      if (n == 250) begin
        start <= 1'b0;
        @(posedge clk);
        while (rot_exp_q.size() != 0 || sent_q.size() != 0) @(posedge clk);
      end
      send_item(rand_item());
    end
    start <= 1'b0;
    while (rot_exp_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (n_bad == 0) begin
      $display("PASS axis_angle_vector_rotate_unit");
    end else begin
      $display("FAIL axis_angle_vector_rotate_unit");
    end
    $finish;
  end

  initial begin
    #2ms;
    $display("FAIL axis_angle_vector_rotate_unit");
    $finish;
  end

endmodule
